@@ sv/cadenced_tone_generator_defines.svh @@
// Assertion macros used by the checker of the tone generator.
`ifndef CADENCED_TONE_GENERATOR_DEFINES_SVH
`define CADENCED_TONE_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CTG_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tone generator check failed");

// Next-cycle implication, disabled during reset.
`define CTG_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tone generator check failed");

`endif

@@ sv/ctg_pkg.sv @@
package ctg_pkg;

    localparam int CTG_PHASE_BITS      = 32;
    localparam int CTG_SINE_TABLE_BITS = 8;
    localparam int CTG_CFG_ADDR_BITS   = 5;
    localparam int CTG_SAMPLE_BITS     = 16;

    localparam logic [31:0] RST_TONE_A_STEP = 32'd161061274;
    localparam logic [31:0] RST_TONE_B_STEP = 32'd268435456;
    localparam logic [7:0]  RST_FRAMES_SEG  = 8'd10;
    localparam logic [9:0]  RST_SAMPLES_FRM = 10'd160;
    localparam logic [14:0] RST_AMPLITUDE   = 15'd6000;

    // pi/2 in Q28
    localparam logic [63:0] HALF_PI_Q28 = 64'd421657428;

    typedef enum logic [2:0] {
        REG_TONE_A_STEP = 3'd0,
        REG_TONE_B_STEP = 3'd1,
        REG_FRAMES_SEG  = 3'd2,
        REG_SAMPLES_FRM = 3'd3,
        REG_AMPLITUDE   = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        SEG_TONE_A  = 2'd0,
        SEG_TONE_B  = 2'd1,
        SEG_SILENCE = 2'd2
    } t_seg;

    // Quarter-wave entry in Q15: Taylor series in Q28 up to x^13, rounded half up.
    function automatic logic [15:0] sine_entry(input int unsigned k,
                                               input int unsigned tbits);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        x    = (HALF_PI_Q28 * 64'(k)) >> tbits;
        term = x;
        sum  = x;
        term = (((term * x) >> 28) * x) >> 28;
        term = term / 64'd6;
        sum  = sum - term;
        term = (((term * x) >> 28) * x) >> 28;
        term = term / 64'd20;
        sum  = sum + term;
        term = (((term * x) >> 28) * x) >> 28;
        term = term / 64'd42;
        sum  = sum - term;
        term = (((term * x) >> 28) * x) >> 28;
        term = term / 64'd72;
        sum  = sum + term;
        term = (((term * x) >> 28) * x) >> 28;
        term = term / 64'd110;
        sum  = sum - term;
        term = (((term * x) >> 28) * x) >> 28;
        term = term / 64'd156;
        sum  = sum + term;
        sum  = (sum + 64'd4096) >> 13;
        if (sum > 64'd32768) begin
            sum = 64'd32768;
        end
        return sum[15:0];
    endfunction

endpackage

@@ sv/ctg_sine_rom.sv @@
module ctg_sine_rom import ctg_pkg::*; #(
    parameter int TABLE_BITS = CTG_SINE_TABLE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [TABLE_BITS:0]   i_addr,
    output logic [15:0]           o_data
);

    localparam int TBL_N = 1 << TABLE_BITS;

    logic [15:0] rom_q15 [TBL_N+1];
    logic [15:0] r_data;

    for (genvar k = 0; k <= TBL_N; k++) begin : g_rom
        localparam logic [15:0] ENTRY = sine_entry(int'(k), TABLE_BITS);
        assign rom_q15[k] = ENTRY;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= rom_q15[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

@@ sv/cadenced_tone_generator.sv @@
// Cadenced tone generator.
// Slave stream: each beat carries a tick in s_tdata[0]. A beat with tick high
// yields one master beat; a beat with tick low is taken and dropped.
// Master stream: m_tdata is the signed 16-bit PCM sample, m_tlast marks the
// last sample of a frame, m_tuser gives the segment (tone A, tone B, silence).
// Frames of samples_per_frame samples cycle through the three segments, each
// frames_per_segment frames long. Tones read a quarter-wave sine table in a
// synchronous ROM and scale it by amplitude; silence outputs zero.
// A sample reaches the master side through the ROM stage and the output stage.
// Throughput: one sample per cycle while m_tready does not stall; the phase and
// frame counters update in the accept cycle, and the ROM read and the scaling
// multiply each take one stage.
// Reset (synchronous, active low) clears phase and counters, empties the
// pipeline and loads the register defaults.
// A stalled receiver holds the output beat; one more tick is still taken into the ROM
// stage, after which s_tready drops until the output drains. The user writes registers
// through the APB port only while the stream is idle; the block does not enforce it.
module cadenced_tone_generator import ctg_pkg::*; #(
    parameter int PHASE_BITS      = CTG_PHASE_BITS,
    parameter int SINE_TABLE_BITS = CTG_SINE_TABLE_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [0] tick, [7:1] zero
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [CTG_SAMPLE_BITS-1:0]   m_tdata,   // [15:0] sample
    output logic                         m_tlast,
    output logic [1:0]                   m_tuser,   // [1:0] segment
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [CTG_CFG_ADDR_BITS-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int ADDR_BITS = SINE_TABLE_BITS + 1;
    localparam int STEP_UP   = (PHASE_BITS > 32) ? PHASE_BITS - 32 : 0;
    localparam int STEP_DN   = (PHASE_BITS < 32) ? 32 - PHASE_BITS : 0;
    localparam logic [ADDR_BITS-1:0] TBL_N = ADDR_BITS'(1) << SINE_TABLE_BITS;

    // configuration
    logic [31:0] r_tone_a_step;
    logic [31:0] r_tone_b_step;
    logic [7:0]  r_frames_seg;
    logic [9:0]  r_samples_frm;
    logic [14:0] r_amplitude;

    t_reg_idx cfg_idx;
    logic     cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = t_reg_idx'(paddr[CTG_CFG_ADDR_BITS-1:2]);
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_comb begin
        case (cfg_idx)
            REG_TONE_A_STEP: prdata = r_tone_a_step;
            REG_TONE_B_STEP: prdata = r_tone_b_step;
            REG_FRAMES_SEG:  prdata = 32'(r_frames_seg);
            REG_SAMPLES_FRM: prdata = 32'(r_samples_frm);
            REG_AMPLITUDE:   prdata = 32'(r_amplitude);
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tone_a_step <= RST_TONE_A_STEP;
            r_tone_b_step <= RST_TONE_B_STEP;
            r_frames_seg  <= RST_FRAMES_SEG;
            r_samples_frm <= RST_SAMPLES_FRM;
            r_amplitude   <= RST_AMPLITUDE;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_TONE_A_STEP: r_tone_a_step <= pwdata;
                REG_TONE_B_STEP: r_tone_b_step <= pwdata;
                REG_FRAMES_SEG:  r_frames_seg  <= pwdata[7:0];
                REG_SAMPLES_FRM: r_samples_frm <= pwdata[9:0];
                REG_AMPLITUDE:   r_amplitude   <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    // generator state
    logic [PHASE_BITS-1:0] r_phase;
    logic [9:0]            r_cfi;
    logic [9:0]            r_fsi;

    // pipeline control
    logic r_s1_valid;
    logic r_m_valid;
    logic out_load;
    logic accept_tick;

    assign out_load    = !r_m_valid | m_tready;
    assign s_tready    = !r_s1_valid | out_load;
    assign accept_tick = s_tvalid & s_tready & s_tdata[0];

    // frame and segment position
    logic [7:0]  fps_eff;
    logic [9:0]  spf_eff;
    logic [9:0]  cad_len;
    logic [9:0]  two_fps;
    logic [9:0]  cfi_eff;
    logic [9:0]  cfi_inc;
    logic [9:0]  n_cfi;
    logic [9:0]  n_fsi;
    logic        frame_end;
    t_seg        seg;
    logic        is_tone;

    always_comb begin
        fps_eff   = (r_frames_seg == 8'd0) ? 8'd1 : r_frames_seg;
        spf_eff   = (r_samples_frm == 10'd0) ? 10'd1 : r_samples_frm;
        two_fps   = 10'({fps_eff, 1'b0});
        cad_len   = two_fps + 10'(fps_eff);
        cfi_eff   = (r_cfi >= cad_len) ? 10'd0 : r_cfi;
        if (cfi_eff < 10'(fps_eff)) begin
            seg = SEG_TONE_A;
        end else if (cfi_eff < two_fps) begin
            seg = SEG_TONE_B;
        end else begin
            seg = SEG_SILENCE;
        end
        is_tone   = (seg != SEG_SILENCE);
        frame_end = (11'(r_fsi) + 11'd1) >= 11'(spf_eff);
        cfi_inc   = cfi_eff + 10'd1;
        if (frame_end) begin
            n_fsi = 10'd0;
            n_cfi = (cfi_inc >= cad_len) ? 10'd0 : cfi_inc;
        end else begin
            n_fsi = r_fsi + 10'd1;
            n_cfi = cfi_eff;
        end
    end

    // phase step and table address
    logic [31:0]           step_sel;
    logic [63:0]           step_wide;
    logic [PHASE_BITS-1:0] step_al;
    logic [1:0]            quad;
    logic [ADDR_BITS-1:0]  idx;
    logic [ADDR_BITS-1:0]  rom_addr;

    always_comb begin
        step_sel  = (seg == SEG_TONE_A) ? r_tone_a_step : r_tone_b_step;
        step_wide = (64'(step_sel) << STEP_UP) >> STEP_DN;
        step_al   = step_wide[PHASE_BITS-1:0];
        quad      = r_phase[PHASE_BITS-1 -: 2];
        idx       = {1'b0, r_phase[PHASE_BITS-3 -: SINE_TABLE_BITS]};
        rom_addr  = quad[0] ? (TBL_N - idx) : idx;
    end

    logic [15:0] rom_mag;

    ctg_sine_rom #(
        .TABLE_BITS (SINE_TABLE_BITS)
    ) u_sine_rom (
        .i_clk  (i_clk),
        .i_en   (s_tready),
        .i_addr (rom_addr),
        .o_data (rom_mag)
    );

    // stage 1 side data, stage 2 output payload
    logic        r_s1_neg;
    logic        r_s1_tone;
    logic        r_s1_end;
    t_seg        r_s1_seg;
    logic [15:0] r_m_sample;
    logic        r_m_last;
    t_seg        r_m_seg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= '0;
            r_cfi      <= '0;
            r_fsi      <= '0;
            r_s1_valid <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            if (accept_tick) begin
                r_cfi <= n_cfi;
                r_fsi <= n_fsi;
                if (is_tone) begin
                    r_phase <= r_phase + step_al;
                end
            end
            if (s_tready) begin
                r_s1_valid <= accept_tick;
            end
            if (out_load) begin
                r_m_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tready) begin
            r_s1_neg  <= quad[1];
            r_s1_tone <= is_tone;
            r_s1_end  <= frame_end;
            r_s1_seg  <= seg;
        end
    end

    // scale: truncation toward zero by scaling the magnitude, then negate
    logic [30:0] prod;
    logic [15:0] mag_scaled;
    logic [15:0] n_sample;

    always_comb begin
        prod       = 31'(r_amplitude) * 31'(rom_mag);
        mag_scaled = prod[30:15];
        if (!r_s1_tone) begin
            n_sample = 16'd0;
        end else if (r_s1_neg) begin
            n_sample = 16'd0 - mag_scaled;
        end else begin
            n_sample = mag_scaled;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_s1_valid) begin
            r_m_sample <= n_sample;
            r_m_last   <= r_s1_end;
            r_m_seg    <= r_s1_seg;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_sample;
    assign m_tlast  = r_m_last;
    assign m_tuser  = r_m_seg;

endmodule

@@ sv/ctg_checker.sv @@
`include "cadenced_tone_generator_defines.svh"

module ctg_checker import ctg_pkg::*; (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [CTG_SAMPLE_BITS-1:0]   m_tdata,
    input logic [1:0]                   m_tuser
);

    // a stalled beat stays valid
    `CTG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_tvalid && !m_tready, m_tvalid)
    // silence carries zero samples
    `CTG_ASSERT_IMPL(a_silence_zero, i_clk, i_rst_n, m_tvalid && (m_tuser == SEG_SILENCE), m_tdata == '0)
    // the segment code is never out of range
    `CTG_ASSERT_IMPL(a_seg_range, i_clk, i_rst_n, m_tvalid, m_tuser <= SEG_SILENCE)
    // a drained output side always takes the next beat
    `CTG_ASSERT_NEXT(a_ready_after_drain, i_clk, i_rst_n, !m_tvalid && !(s_tvalid && s_tready), s_tready)

endmodule

bind cadenced_tone_generator ctg_checker u_ctg_checker (.*);

@@ sim/cadenced_tone_generator_test.sv @@
module cadenced_tone_generator_test;
    import ctg_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 60;
    localparam int TABLE_SIZE  = 1 << CTG_SINE_TABLE_BITS;

    typedef struct {
        logic [15:0] sample;
        logic        last;
        t_seg        seg;
    } t_tone_beat;

    class tone_scoreboard;
        logic [15:0] sine_q15 [0:TABLE_SIZE];
        logic [31:0] step_a;
        logic [31:0] step_b;
        logic [7:0]  frames_seg;
        logic [9:0]  samples_frm;
        logic [14:0] amp;
        logic [31:0] phase;
        int unsigned frame_idx;
        int unsigned sample_idx;
        t_tone_beat  expected_beats [$];
        int          errors;

        function new();
            logic [63:0] x;
            logic [63:0] term;
            logic [63:0] sum;
            // quarter wave in Q15 from a Q28 Taylor series up to x^13
            for (int k = 0; k <= TABLE_SIZE; k++) begin
                x    = (HALF_PI_Q28 * 64'(k)) >> CTG_SINE_TABLE_BITS;
                term = x;
                sum  = x;
                for (int n = 1; n <= 6; n++) begin
                    term = (((term * x) >> 28) * x) >> 28;
                    term = term / 64'((2 * n) * (2 * n + 1));
                    if (n % 2 == 1) begin
                        sum = sum - term;
                    end else begin
                        sum = sum + term;
                    end
                end
                sum = (sum + 64'd4096) >> 13;
                if (sum > 64'd32768) begin
                    sum = 64'd32768;
                end
                sine_q15[k] = sum[15:0];
            end
            step_a      = RST_TONE_A_STEP;
            step_b      = RST_TONE_B_STEP;
            frames_seg  = RST_FRAMES_SEG;
            samples_frm = RST_SAMPLES_FRM;
            amp         = RST_AMPLITUDE;
            phase       = '0;
            frame_idx   = 0;
            sample_idx  = 0;
            errors      = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [31:0] value);
            case (idx)
                REG_TONE_A_STEP: step_a      = value;
                REG_TONE_B_STEP: step_b      = value;
                REG_FRAMES_SEG:  frames_seg  = value[7:0];
                REG_SAMPLES_FRM: samples_frm = value[9:0];
                REG_AMPLITUDE:   amp         = value[14:0];
                default: ;
            endcase
        endfunction

        function logic [15:0] tone_value(logic [31:0] ph);
            logic [1:0]  quad;
            logic [8:0]  idx;
            logic [31:0] prod;
            quad = ph[CTG_PHASE_BITS-1 -: 2];
            idx  = {1'b0, ph[CTG_PHASE_BITS-3 -: CTG_SINE_TABLE_BITS]};
            // odd quadrants read the table mirrored
            if (quad[0]) begin
                idx = 9'(TABLE_SIZE) - idx;
            end
            prod = (32'(amp) * 32'(sine_q15[idx])) >> 15;
            if (quad[1]) begin
                prod = 32'd0 - prod;
            end
            return prod[15:0];
        endfunction

        function void note_tick(bit tick);
            int unsigned fps;
            int unsigned spf;
            int unsigned seg;
            t_tone_beat  beat;
            if (!tick) begin
                return;
            end
            fps = (frames_seg == 0) ? 1 : frames_seg;
            spf = (samples_frm == 0) ? 1 : samples_frm;
            // restart the cadence if the frame count was lowered under us
            if (frame_idx >= 3 * fps) begin
                frame_idx = 0;
            end
            seg = frame_idx / fps;
            beat.sample = 16'd0;
            if (seg < 2) begin
                beat.sample = tone_value(phase);
                phase = phase + ((seg == 0) ? step_a : step_b);
            end
            beat.last = (sample_idx + 1 >= spf);
            if (beat.last) begin
                sample_idx = 0;
                frame_idx++;
                if (frame_idx >= 3 * fps) begin
                    frame_idx = 0;
                end
            end else begin
                sample_idx++;
            end
            beat.seg = t_seg'(seg[1:0]);
            expected_beats.push_back(beat);
        endfunction

        function void check_beat(logic [15:0] sample, logic last, logic [1:0] seg);
            t_tone_beat beat;
            if (expected_beats.size() == 0) begin
                $error("unexpected output beat: sample %0d", $signed(sample));
                errors++;
                return;
            end
            beat = expected_beats.pop_front();
            if (sample !== beat.sample) begin
                $error("sample mismatch: expected %0d, actual %0d",
                       $signed(beat.sample), $signed(sample));
                errors++;
            end
            if (last !== beat.last) begin
                $error("frame_end mismatch: expected %0d, actual %0d", beat.last, last);
                errors++;
            end
            if (seg !== beat.seg) begin
                $error("segment mismatch: expected %0d, actual %0d", beat.seg, seg);
                errors++;
            end
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [0] tick, [7:1] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [15:0] sample
    logic        m_tlast;
    logic [1:0]  m_tuser;   // [1:0] segment
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [CTG_CFG_ADDR_BITS-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    bit calm;
    bit hold_out;

    tone_scoreboard tones = new();

    cadenced_tone_generator DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #4 i_clk = ~i_clk;
        end
    end

    // receiver: random backpressure, or a long hold when asked
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_out) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_out = 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(99) >= 21);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            tones.check_beat(m_tdata, m_tlast, m_tuser);
        end
    end

    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    task automatic pause(int n);
        repeat (n) begin
            @(negedge i_clk);
            s_tvalid <= 1'b0;
        end
    endtask

    task automatic send_tick(bit tick);
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, tick};
        do @(posedge i_clk); while (!s_tready);
        tones.note_tick(tick);
    endtask

    // idle each cycle with the same odds as the receiver
    task automatic offer_tick(bit tick);
        if (!calm) begin
            while ($urandom_range(99) < 21) begin
                pause(1);
            end
        end
        send_tick(tick);
    endtask

    // drop valid, wait out every sample in flight plus the pipeline
    task automatic settle();
        pause(1);
        while (tones.pending() != 0) @(posedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic apb_write(t_reg_idx idx, logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        tones.set_reg(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_all(logic [31:0] a, logic [31:0] b, logic [7:0] fps,
                             logic [9:0] spf, logic [14:0] amp_v);
        apb_write(REG_TONE_A_STEP, a);
        apb_write(REG_TONE_B_STEP, b);
        apb_write(REG_FRAMES_SEG, 32'(fps));
        apb_write(REG_SAMPLES_FRM, 32'(spf));
        apb_write(REG_AMPLITUDE, 32'(amp_v));
    endtask

    function automatic logic [31:0] pick_step();
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0) begin
            return 32'd0;
        end else if (r == 1) begin
            return 32'hFFFF_FFFF;
        end
        return $urandom;
    endfunction

    initial begin
        logic [7:0]  fps;
        logic [9:0]  spf;
        logic [14:0] amp_v;
        int unsigned r;
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'd0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = 32'd0;
        calm     = 1'b0;
        hold_out = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // register defaults straight out of reset
        send_tick(1'b1);
        send_tick(1'b1);
        settle();

        // full-scale step and amplitude, frozen tone B, two-sample frames
        write_all(32'hFFFF_FFFF, 32'd0, 8'd1, 10'd2, 15'd32767);
        send_tick(1'b1);
        send_tick(1'b0);
        repeat (5) send_tick(1'b1);
        settle();

        // zero sizes behave as one; quarter- and eighth-turn steps visit three of the four quadrants
        write_all(32'h4000_0000, 32'h2000_0000, 8'd0, 10'd0, 15'd20000);
        repeat (6) send_tick(1'b1);
        settle();

        // silent amplitude, then shrink sizes below the running indexes
        write_all(32'h0123_4567, 32'h89AB_CDEF, 8'd3, 10'd2, 15'd0);
        repeat (9) send_tick(1'b1);
        settle();
        apb_write(REG_FRAMES_SEG, 32'd1);
        apb_write(REG_SAMPLES_FRM, 32'd1);
        apb_write(REG_AMPLITUDE, 32'd1);
        repeat (3) send_tick(1'b1);

        for (int ph = 0; ph < 8; ph++) begin
            settle();
            fps = (ph == 6) ? 8'd255 : 8'($urandom_range(0, 4));
            spf = (ph == 6) ? 10'd1023 : 10'($urandom_range(0, 12));
            r = $urandom_range(5);
            amp_v = (r == 0) ? 15'd0 : (r == 1) ? 15'd32767 : 15'($urandom_range(32767));
            write_all(pick_step(), pick_step(), fps, spf, amp_v);
            calm = (ph == 1);
            if (ph == 3) begin
                // stall the output long enough that the input backs up
                hold_out = 1'b1;
                repeat (20) send_tick(1'b1);
            end
            for (int i = 0; i < 52; i++) begin
                if (ph == 5 && i == 26) begin
                    settle();
                end
                offer_tick($urandom_range(99) >= 10);
            end
            calm = 1'b0;
        end

        pause(1);
        while (tones.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (tones.errors == 0 && tones.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/ctg_pkg.sv
sv/ctg_sine_rom.sv
sv/cadenced_tone_generator.sv
sv/ctg_checker.sv
sim/cadenced_tone_generator_test.sv
